// File: rtl/afp_pkg.sv
// Shared types and codes for the advertisement frame parser.
// Used by afp_parse, afp_rsp_queue and advertisement_frame_parser_unit.
`default_nettype none

package afp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_SALT   = 2'd0;
   localparam logic [1:0] KIND_KEY    = 2'd1;
   localparam logic [1:0] KIND_NAME   = 2'd2;
   localparam logic [1:0] KIND_REPORT = 2'd3;

   // Report status codes.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
   localparam logic [2:0] ST_BAD_VERSION = 3'd2;
   localparam logic [2:0] ST_BAD_NAME    = 3'd3;
   localparam logic [2:0] ST_BAD_TLV     = 3'd4;
   localparam logic [2:0] ST_BAD_VENDOR  = 3'd5;

   // Element type code of the vendor element, and the one vendor id kept.
   localparam logic [7:0] TLV_TYPE_VENDOR = 8'd2;
   localparam logic [7:0] VENDOR_KEPT     = 8'd1;
   localparam logic [7:0] VENDOR_LEN_OK   = 8'd1;

   // Highest device type code; larger ones decode to unknown.
   localparam logic [2:0] DEV_CLASS_MAX  = 3'd5;
   localparam logic [2:0] DEVICE_UNKNOWN = 3'd0;

   // Saturation point of the frame byte counter.
   localparam logic [7:0] TOTAL_MAX = 8'hff;

   localparam int unsigned QueueDepth = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic [7:0] field_index;
      logic [2:0] status;
      logic [2:0] version;
      logic [2:0] dev_class;
      logic       has_name;
      logic [7:0] name_length;
      logic       vendor;
      logic       last;
   } result_type;

   // What the parser hands to the result queue in one cycle.
   typedef struct packed {
      logic data_valid;
      logic report_valid;
   } push_type;

endpackage

`default_nettype wire

// File: rtl/afp_parse.sv
// Frame parsing state machine: one byte per cycle while accept is high, up to two results per byte.
// Depends on afp_pkg.
`default_nettype none

module afp_parse #(
   parameter int unsigned SaltBytes    = 2,
   parameter int unsigned KeyHashBytes = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         data_byte,
   input  wire logic               frame_end,
   input  wire logic [2:0]         max_version,
   output afp_pkg::push_type       push,
   output afp_pkg::result_type     data_result,
   output afp_pkg::result_type     report_result
);

   localparam int unsigned MinFrame = 1 + SaltBytes + KeyHashBytes;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_SALT    = 3'd1,
      PH_KEY     = 3'd2,
      PH_NAMELEN = 3'd3,
      PH_NAME    = 3'd4,
      PH_TYPE    = 3'd5,
      PH_LEN     = 3'd6,
      PH_VAL     = 3'd7
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] field_count_ff, field_count_in;
   logic [7:0] total_count_ff, total_count_in;
   logic [2:0] hdr_version_ff, hdr_version_in;
   logic [2:0] hdr_type_ff, hdr_type_in;
   logic       hdr_has_name_ff, hdr_has_name_in;
   logic [7:0] name_length_ff, name_length_in;
   logic [7:0] tlv_remaining_ff, tlv_remaining_in;
   logic       tlv_is_vendor_ff, tlv_is_vendor_in;
   logic       vendor_bad_ff, vendor_bad_in;
   logic       vendor_value_ff, vendor_value_in;
   logic [2:0] error_code_ff, error_code_in;

   logic [7:0] field_inc;
   logic [7:0] tlv_dec;
   logic       len_bad;
   logic [1:0] data_kind;
   logic       data_emit;
   logic [2:0] status;

   assign field_inc = field_count_ff + 8'd1;
   assign tlv_dec   = (tlv_remaining_ff != 8'd0) ? tlv_remaining_ff - 8'd1 : 8'd0;
   assign len_bad   = tlv_is_vendor_ff && (data_byte != afp_pkg::VENDOR_LEN_OK);

   // Next frame state for the byte on the input, before the end-of-frame clear.
   always_comb begin
      phase_in         = phase_ff;
      field_count_in   = field_count_ff;
      total_count_in   = (total_count_ff == afp_pkg::TOTAL_MAX) ? total_count_ff
                                                                : total_count_ff + 8'd1;
      hdr_version_in   = hdr_version_ff;
      hdr_type_in      = hdr_type_ff;
      hdr_has_name_in  = hdr_has_name_ff;
      name_length_in   = name_length_ff;
      tlv_remaining_in = tlv_remaining_ff;
      tlv_is_vendor_in = tlv_is_vendor_ff;
      vendor_bad_in    = vendor_bad_ff;
      vendor_value_in  = vendor_value_ff;
      error_code_in    = error_code_ff;
      data_emit        = 1'b0;
      data_kind        = afp_pkg::KIND_SALT;

      if (error_code_ff == afp_pkg::ST_OK) begin
         unique case (phase_ff)
            PH_HEADER: begin
               hdr_version_in  = data_byte[7:5];
               hdr_has_name_in = ~data_byte[4];
               hdr_type_in     = (data_byte[3:1] > afp_pkg::DEV_CLASS_MAX)
                                 ? afp_pkg::DEVICE_UNKNOWN : data_byte[3:1];
               field_count_in  = 8'd0;
               phase_in        = PH_SALT;
            end
            PH_SALT: begin
               data_emit      = 1'b1;
               data_kind      = afp_pkg::KIND_SALT;
               field_count_in = field_inc;
               if (field_inc >= 8'(SaltBytes)) begin
                  field_count_in = 8'd0;
                  phase_in       = PH_KEY;
               end
            end
            PH_KEY: begin
               data_emit      = 1'b1;
               data_kind      = afp_pkg::KIND_KEY;
               field_count_in = field_inc;
               if (field_inc >= 8'(KeyHashBytes)) begin
                  field_count_in = 8'd0;
                  phase_in       = hdr_has_name_ff ? PH_NAMELEN : PH_TYPE;
               end
            end
            PH_NAMELEN: begin
               name_length_in = data_byte;
               field_count_in = 8'd0;
               if (data_byte == 8'd0) begin
                  error_code_in = afp_pkg::ST_BAD_NAME;
               end else begin
                  phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               data_emit      = 1'b1;
               data_kind      = afp_pkg::KIND_NAME;
               field_count_in = field_inc;
               if (field_inc >= name_length_ff) begin
                  field_count_in = 8'd0;
                  phase_in       = PH_TYPE;
               end
            end
            PH_TYPE: begin
               tlv_is_vendor_in = (data_byte == afp_pkg::TLV_TYPE_VENDOR);
               phase_in         = PH_LEN;
            end
            PH_LEN: begin
               vendor_bad_in = len_bad;
               if (data_byte == 8'd0) begin
                  if (len_bad) begin
                     error_code_in = afp_pkg::ST_BAD_VENDOR;
                  end
                  phase_in = PH_TYPE;
               end else begin
                  tlv_remaining_in = data_byte;
                  phase_in         = PH_VAL;
               end
            end
            PH_VAL: begin
               if (tlv_is_vendor_ff && !vendor_bad_ff) begin
                  vendor_value_in = (data_byte == afp_pkg::VENDOR_KEPT);
               end
               tlv_remaining_in = tlv_dec;
               if (tlv_dec == 8'd0) begin
                  if (vendor_bad_ff) begin
                     error_code_in = afp_pkg::ST_BAD_VENDOR;
                  end
                  phase_in = PH_TYPE;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   // Report status, in order of precedence, from the updated frame state.
   always_comb begin
      priority if (total_count_in < 8'(MinFrame)) begin
         status = afp_pkg::ST_TOO_SHORT;
      end else if (hdr_version_in > max_version) begin
         status = afp_pkg::ST_BAD_VERSION;
      end else if (error_code_in != afp_pkg::ST_OK) begin
         status = error_code_in;
      end else if (phase_in == PH_NAMELEN || phase_in == PH_NAME) begin
         status = afp_pkg::ST_BAD_NAME;
      end else if (phase_in == PH_VAL && tlv_remaining_in != 8'd0) begin
         status = afp_pkg::ST_BAD_TLV;
      end else begin
         status = afp_pkg::ST_OK;
      end
   end

   always_comb begin
      push.data_valid   = accept && data_emit;
      push.report_valid = accept && frame_end;

      data_result             = '0;
      data_result.kind        = data_kind;
      data_result.payload     = data_byte;
      data_result.field_index = field_count_ff;

      report_result             = '0;
      report_result.kind        = afp_pkg::KIND_REPORT;
      report_result.status      = status;
      report_result.version     = hdr_version_in;
      report_result.dev_class   = hdr_type_in;
      report_result.has_name    = hdr_has_name_in;
      report_result.name_length = name_length_in;
      report_result.vendor      = vendor_value_in;
      report_result.last        = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && frame_end)) begin
         phase_ff         <= PH_HEADER;
         field_count_ff   <= 8'd0;
         total_count_ff   <= 8'd0;
         hdr_version_ff   <= 3'd0;
         hdr_type_ff      <= 3'd0;
         hdr_has_name_ff  <= 1'b0;
         name_length_ff   <= 8'd0;
         tlv_remaining_ff <= 8'd0;
         tlv_is_vendor_ff <= 1'b0;
         vendor_bad_ff    <= 1'b0;
         vendor_value_ff  <= 1'b0;
         error_code_ff    <= afp_pkg::ST_OK;
      end else if (accept) begin
         phase_ff         <= phase_in;
         field_count_ff   <= field_count_in;
         total_count_ff   <= total_count_in;
         hdr_version_ff   <= hdr_version_in;
         hdr_type_ff      <= hdr_type_in;
         hdr_has_name_ff  <= hdr_has_name_in;
         name_length_ff   <= name_length_in;
         tlv_remaining_ff <= tlv_remaining_in;
         tlv_is_vendor_ff <= tlv_is_vendor_in;
         vendor_bad_ff    <= vendor_bad_in;
         vendor_value_ff  <= vendor_value_in;
         error_code_ff    <= error_code_in;
      end
   end

`ifndef SYNTH
   // Once an error is latched the frame yields no more data words.
   a_no_data_after_error: assert property (@(posedge clock) disable iff (reset)
      (error_code_ff != afp_pkg::ST_OK) |-> !push.data_valid)
      else $error("data word emitted after a frame error");

   // A report leaves the parser at the start of a fresh frame.
   a_clear_after_report: assert property (@(posedge clock) disable iff (reset)
      push.report_valid |=> (phase_ff == PH_HEADER && total_count_ff == 8'd0))
      else $error("frame state not cleared after report");

   // The header phase is only ever seen before the first byte of a frame.
   a_header_fresh: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (total_count_ff == 8'd0))
      else $error("header phase with bytes already counted");
`endif

endmodule

`default_nettype wire

// File: rtl/afp_rsp_queue.sv
// Result queue: takes up to two results a cycle, hands out one per word.
// Depends on afp_pkg.
`default_nettype none

module afp_rsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire afp_pkg::push_type    push,
   input  wire afp_pkg::result_type  data_result,
   input  wire afp_pkg::result_type  report_result,
   output logic                      in_stall,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output afp_pkg::result_type       out_result
);

   localparam int unsigned Depth  = afp_pkg::QueueDepth;
   localparam int unsigned PtrW   = $clog2(Depth);
   localparam int unsigned CountW = $clog2(Depth + 1);

   afp_pkg::result_type entry_ff [Depth];

   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [PtrW-1:0]   report_slot;
   logic              pop;
   logic [CountW-1:0] n_push;

   assign pop         = out_valid && !out_stall;
   assign n_push      = CountW'(push.data_valid) + CountW'(push.report_valid);
   assign report_slot = wr_ptr_ff + PtrW'(push.data_valid);
   assign wr_ptr_in   = wr_ptr_ff + PtrW'(n_push);
   assign rd_ptr_in   = rd_ptr_ff + PtrW'(pop);
   assign count_in    = count_ff + n_push - CountW'(pop);

   assign out_valid  = (count_ff != '0);
   assign out_result = entry_ff[rd_ptr_ff];
   // Hold off the byte stream unless two free slots are certain.
   assign in_stall   = (count_ff > CountW'(Depth - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.data_valid) begin
         entry_ff[wr_ptr_ff] <= data_result;
      end
      if (push.report_valid) begin
         entry_ff[report_slot] <= report_result;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(Depth))
      else $error("result queue overflow");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == PtrW'(count_ff))
      else $error("queue pointers disagree with fill count");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push.data_valid || push.report_valid) |=> out_valid)
      else $error("pushed result not offered");
`endif

endmodule

`default_nettype wire

// File: rtl/advertisement_frame_parser_unit.sv
// Top level of the advertisement frame parser: version register, parser, result queue.
// Depends on afp_pkg, afp_parse and afp_rsp_queue.
//
//   Channel  Direction  Handshake            Word
//   req_     in         req_valid/req_stall  one frame byte and its end-of-frame flag
//   rsp_     out        rsp_valid/rsp_stall  one result: data byte or final report
//   csr_     in         csr_valid/csr_ready  new max_version value
//
// A byte is parsed in the cycle it is accepted; its results enter a four-entry
// queue and are offered on rsp_ in order, behind any results already queued.
// One byte is taken every cycle while results drain; a last byte that also carries
// a data byte yields two results, which leave the queue one after the other.
// req_stall rises when the queue holds more than two results, so it depends only on
// the queue fill and not on rsp_stall directly.
// Synchronous reset clears the frame state and queue and sets max_version to 1.
`default_nettype none

module advertisement_frame_parser_unit #(
   parameter int unsigned SALT_BYTES     = 2,
   parameter int unsigned KEY_HASH_BYTES = 14
) (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_frame_end,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_payload,
   output logic [7:0]      rsp_field_index,
   output logic [2:0]      rsp_status,
   output logic [2:0]      rsp_version,
   output logic [2:0]      rsp_dev_class,
   output logic            rsp_has_name,
   output logic [7:0]      rsp_name_length,
   output logic            rsp_vendor,
   output logic            rsp_last,

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [2:0] csr_max_version
);

   logic [2:0]          max_version_ff;
   logic                req_accept;
   afp_pkg::push_type   push;
   afp_pkg::result_type data_result;
   afp_pkg::result_type report_result;
   afp_pkg::result_type out_result;

   // The version register can be written at any time; software must write it only
   // between frames, which the block itself does not enforce.
   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_version_ff <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         max_version_ff <= csr_max_version;
      end
   end

   afp_parse #(
      .SaltBytes    (SALT_BYTES),
      .KeyHashBytes (KEY_HASH_BYTES)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .data_byte     (req_data_byte),
      .frame_end     (req_frame_end),
      .max_version   (max_version_ff),
      .push          (push),
      .data_result   (data_result),
      .report_result (report_result)
   );

   afp_rsp_queue u_rsp_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .data_result   (data_result),
      .report_result (report_result),
      .in_stall      (req_stall),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_result    (out_result)
   );

   // Fan the queued result out to the field ports.
   assign rsp_kind        = out_result.kind;
   assign rsp_payload     = out_result.payload;
   assign rsp_field_index = out_result.field_index;
   assign rsp_status      = out_result.status;
   assign rsp_version     = out_result.version;
   assign rsp_dev_class   = out_result.dev_class;
   assign rsp_has_name    = out_result.has_name;
   assign rsp_name_length = out_result.name_length;
   assign rsp_vendor      = out_result.vendor;
   assign rsp_last        = out_result.last;

endmodule

`default_nettype wire
